@@ hw/rtl/pad_pkg.sv @@
`default_nettype none

package pad_pkg;

  // register indexes of the configuration port
  localparam logic [2:0] CFG_ATT_X   = 3'd0;
  localparam logic [2:0] CFG_ATT_Y   = 3'd1;
  localparam logic [2:0] CFG_ATT_Z   = 3'd2;
  localparam logic [2:0] CFG_FALLOFF = 3'd3;
  localparam logic [2:0] CFG_ENV     = 3'd4;

  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [23:0] FALL_MIN  = 24'd65536;
  localparam logic [23:0] FALL_RST  = 24'd98304;

  // square root unit: 72-bit radicand, one root bit per stage
  localparam int SQ_IN_W  = 72;
  localparam int SQ_OUT_W = 36;
  localparam int SQ_REM_W = 38;

  // divider unit: 58-bit dividend, 33-bit divisor, 26 quotient bits
  localparam int DV_N_W = 58;
  localparam int DV_D_W = 33;
  localparam int DV_Q_W = 26;
  localparam int DV_R_W = 34;

  // pipeline depth of the top level (input register to output register)
  localparam int NST    = 135;
  localparam int SIDE_N = 134;
  localparam int ST_LEN = 40;

  typedef struct packed {
    logic [2:0][31:0] p;
    logic [16:0]      w;
    logic [2:0][32:0] m;
    logic [2:0]       neg;
    logic [32:0]      len;
  } side_t;

  // round(att * env / 2^16) on the magnitude, half away from zero
  function automatic logic [32:0] scale_att(input logic [31:0] att, input logic [16:0] env);
    logic [31:0] mag;
    logic [48:0] prod;
    logic [48:0] rnd;
    logic [32:0] r;
    mag  = att[31] ? (32'd0 - att) : att;
    prod = {17'd0, mag} * {32'd0, env};
    rnd  = prod + 49'd32768;
    r    = rnd[48:16];
    return att[31] ? (33'd0 - r) : r;
  endfunction

  function automatic logic [31:0] sat32(input logic [33:0] v);
    logic [31:0] r;
    if (!v[33] && (v[32:31] != 2'b00)) begin
      r = 32'h7fff_ffff;
    end else if (v[33] && (v[32:31] != 2'b11)) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/point_attractor_deform_top.sv @@
// throughput: one item per cycle; the whole pipeline advances together and
// holds when the output register is full and not taken
// depth is set by two 36-stage square root units and two 26-stage dividers in series on each axis
// reset: asynchronous active low, clears valid bits and loads register defaults
`default_nettype none

module point_attractor_deform_top import pad_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] point_x_i,
  input  wire logic [31:0] point_y_i,
  input  wire logic [31:0] point_z_i,
  input  wire logic [16:0] weight_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [31:0] moved_x_o,
  output logic      [31:0] moved_y_o,
  output logic      [31:0] moved_z_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  // ---------------- configuration registers ----------------
  logic [2:0][31:0] att_q;
  logic [23:0]      fall_q;
  logic [16:0]      env_q;
  logic [23:0]      fall_eff;
  logic [16:0]      env_eff;
  logic [2:0][32:0] a_q;     // attractor scaled by envelope

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      att_q  <= '0;
      fall_q <= FALL_RST;
      env_q  <= ONE_Q16;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ATT_X:   att_q[0] <= cfg_data_i;
        CFG_ATT_Y:   att_q[1] <= cfg_data_i;
        CFG_ATT_Z:   att_q[2] <= cfg_data_i;
        CFG_FALLOFF: fall_q   <= cfg_data_i[23:0];
        CFG_ENV:     env_q    <= cfg_data_i[16:0];
        default:     ;
      endcase
    end
  end

  // falloff below one acts as one, envelope above one acts as one
  assign fall_eff = (fall_q < FALL_MIN) ? FALL_MIN : fall_q;
  assign env_eff  = (env_q > ONE_Q16) ? ONE_Q16 : env_q;

  // attractor product is refreshed every cycle; user moves config only while idle, not enforced
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      a_q[i] <= scale_att(att_q[i], env_eff);
    end
  end

  // ---------------- pipeline control ----------------
  // one enable for every stage: advance unless the output holds an untaken item
  logic            en;
  logic [NST-1:0]  vld_q;

  assign en          = !vld_q[NST-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // ---------------- side data traveling with the item ----------------
  side_t            side_q [SIDE_N];
  side_t            side_d [SIDE_N];
  logic [2:0][32:0] d_m;
  logic [2:0]       d_neg;
  logic [SQ_OUT_W-1:0] root1;
  logic [SQ_OUT_W-1:0] root2;

  // offset from vertex to attractor and its magnitude
  always_comb begin
    logic [33:0] d;
    logic [33:0] dn;
    for (int i = 0; i < 3; i++) begin
      d        = {a_q[i][32], a_q[i]} - {{2{side_q[0].p[i][31]}}, side_q[0].p[i]};
      dn       = 34'd0 - d;
      d_neg[i] = d[33];
      d_m[i]   = d[33] ? dn[32:0] : d[32:0];
    end
  end

  always_comb begin
    side_d[0]   = '0;
    side_d[0].p = {point_z_i, point_y_i, point_x_i};
    side_d[0].w = (weight_i > ONE_Q16) ? ONE_Q16 : weight_i;
    for (int s = 1; s < SIDE_N; s++) begin
      side_d[s] = side_q[s-1];
      if (s == 1) begin
        side_d[s].m   = d_m;
        side_d[s].neg = d_neg;
      end
      if (s == ST_LEN) begin
        side_d[s].len = root1[32:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < SIDE_N; s++) begin
        side_q[s] <= side_d[s];
      end
    end
  end

  // ---------------- squared length ----------------
  logic [2:0][65:0] sq_q;
  logic [66:0]      sum_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= {33'd0, side_q[1].m[i]} * {33'd0, side_q[1].m[i]};
      end
      sum_q <= {1'b0, sq_q[0]} + {1'b0, sq_q[1]} + {1'b0, sq_q[2]};
    end
  end

  // length, then square root of the length
  pad_sqrt u_sqrt_len (
    .clk_i  (clk_i),
    .en_i   (en),
    .val_i  ({5'd0, sum_q}),
    .root_o (root1)
  );

  pad_sqrt u_sqrt_root (
    .clk_i  (clk_i),
    .en_i   (en),
    .val_i  ({23'd0, root1[32:0], 16'd0}),
    .root_o (root2)
  );

  // ---------------- per-axis scale and divisions ----------------
  logic [2:0][57:0] prod_q;
  logic [2:0][57:0] num1_q;
  logic [2:0][57:0] num2_q;
  logic [2:0][42:0] tw_q;
  logic [2:0][59:0] tt_q;
  logic [2:0][28:0] t3_q;
  logic [2:0][31:0] moved_q;
  logic [DV_Q_W-1:0] t1 [3];
  logic [DV_Q_W-1:0] t2 [3];

  for (genvar i = 0; i < 3; i++) begin : g_axis
    // |d| * root / len, rounded
    pad_div u_div_len (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num1_q[i]),
      .den_i (side_q[77].len),
      .quo_o (t1[i])
    );

    // divide by falloff, rounded
    pad_div u_div_fall (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num2_q[i]),
      .den_i ({9'd0, fall_eff}),
      .quo_o (t2[i])
    );
  end

  always_ff @(posedge clk_i) begin
    logic [60:0] rnd;
    logic [33:0] pe;
    logic [33:0] te;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= {25'd0, side_q[75].m[i]} * {33'd0, root2[24:0]};
        num1_q[i] <= prod_q[i] + {26'd0, side_q[76].len[32:1]};
        num2_q[i] <= {17'd0, t1[i][24:0], 16'd0} + {35'd0, fall_eff[23:1]};
        tw_q[i]   <= {17'd0, t2[i]} * {26'd0, side_q[130].w};
        tt_q[i]   <= {17'd0, tw_q[i]} * {43'd0, env_eff};
        rnd        = {1'b0, tt_q[i]} + 61'h0_8000_0000;
        t3_q[i]   <= rnd[60:32];
        // apply the move with its sign, saturate; zero length keeps the vertex
        pe = {{2{side_q[133].p[i][31]}}, side_q[133].p[i]};
        te = {5'd0, t3_q[i]};
        if (side_q[133].len == '0) begin
          moved_q[i] <= side_q[133].p[i];
        end else if (side_q[133].neg[i]) begin
          moved_q[i] <= sat32(pe - te);
        end else begin
          moved_q[i] <= sat32(pe + te);
        end
      end
    end
  end

  assign moved_x_o = moved_q[0];
  assign moved_y_o = moved_q[1];
  assign moved_z_o = moved_q[2];

endmodule

`default_nettype wire

@@ hw/rtl/pad_sqrt.sv @@
`default_nettype none

module pad_sqrt import pad_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire logic [SQ_IN_W-1:0]  val_i,
  output logic      [SQ_OUT_W-1:0] root_o
);

  logic [SQ_REM_W-1:0] rem_q  [SQ_OUT_W];
  logic [SQ_OUT_W-1:0] root_q [SQ_OUT_W];
  logic [SQ_IN_W-1:0]  val_q  [SQ_OUT_W];

  for (genvar k = 0; k < SQ_OUT_W; k++) begin : g_stage
    logic [SQ_REM_W-1:0] rem_in;
    logic [SQ_OUT_W-1:0] root_in;
    logic [SQ_IN_W-1:0]  val_in;
    logic [SQ_REM_W+1:0] rem2;
    logic [SQ_REM_W+1:0] trial;
    logic [SQ_REM_W+1:0] diff;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = val_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign val_in  = val_q[k-1];
    end

    assign rem2  = {rem_in, val_in[SQ_IN_W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign diff  = rem2 - trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem2 >= trial) begin
          rem_q[k]  <= diff[SQ_REM_W-1:0];
          root_q[k] <= {root_in[SQ_OUT_W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem2[SQ_REM_W-1:0];
          root_q[k] <= {root_in[SQ_OUT_W-2:0], 1'b0};
        end
        val_q[k] <= {val_in[SQ_IN_W-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[SQ_OUT_W-1];

endmodule

`default_nettype wire

@@ hw/rtl/pad_div.sv @@
`default_nettype none

module pad_div import pad_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [DV_N_W-1:0] num_i,
  input  wire logic [DV_D_W-1:0] den_i,
  output logic      [DV_Q_W-1:0] quo_o
);

  logic [DV_R_W-1:0] rem_q [DV_Q_W];
  logic [DV_Q_W-1:0] low_q [DV_Q_W];
  logic [DV_D_W-1:0] den_q [DV_Q_W];
  logic [DV_Q_W-1:0] quo_q [DV_Q_W];

  for (genvar k = 0; k < DV_Q_W; k++) begin : g_stage
    logic [DV_R_W-1:0] rem_in;
    logic [DV_Q_W-1:0] low_in;
    logic [DV_D_W-1:0] den_in;
    logic [DV_Q_W-1:0] quo_in;
    logic [DV_R_W:0]   rem2;
    logic [DV_R_W:0]   diff;

    if (k == 0) begin : g_first
      // quotient fits the stage count, so the upper part is below the divisor
      assign rem_in = {{(DV_R_W-(DV_N_W-DV_Q_W)){1'b0}}, num_i[DV_N_W-1:DV_Q_W]};
      assign low_in = num_i[DV_Q_W-1:0];
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign rem2 = {rem_in, low_in[DV_Q_W-1]};
    assign diff = rem2 - {2'b00, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem2 >= {2'b00, den_in}) begin
          rem_q[k] <= diff[DV_R_W-1:0];
          quo_q[k] <= {quo_in[DV_Q_W-2:0], 1'b1};
        end else begin
          rem_q[k] <= rem2[DV_R_W-1:0];
          quo_q[k] <= {quo_in[DV_Q_W-2:0], 1'b0};
        end
        low_q[k] <= {low_in[DV_Q_W-2:0], 1'b0};
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[DV_Q_W-1];

endmodule

`default_nettype wire

@@ hw/rtl/pad_checker.sv @@
`default_nettype none

module pad_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] moved_x_o,
  input wire logic [31:0] moved_y_o,
  input wire logic [31:0] moved_z_o,
  input wire logic        cfg_ready_o
);

  // a result not taken stays with the same payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(moved_x_o)
      && $stable(moved_y_o) && $stable(moved_z_o))
    else $error("result changed while stalled");

  // input side only stalls when the output register holds an untaken item
  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output stall");

  // an empty output never blocks the input
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind point_attractor_deform_top pad_checker u_pad_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .moved_x_o   (moved_x_o),
  .moved_y_o   (moved_y_o),
  .moved_z_o   (moved_z_o),
  .cfg_ready_o (cfg_ready_o)
);

`default_nettype wire

@@ sim/tb_point_attractor_deform_top.sv @@
`timescale 1ns / 1ps

module tb_point_attractor_deform_top;
  import pad_pkg::*;

  // one vertex item and one moved vertex
  typedef struct packed {
    logic [2:0][31:0] p;
    logic [16:0]      w;
  } vertex_t;

  typedef struct packed {
    logic [2:0][31:0] m;
  } moved_t;

  localparam int WDOG_LIMIT = 4000;
  localparam int HOLD_LEN   = 600;
  localparam int PHASE_N    = 6;
  localparam int ITEMS_PER  = 60;
  localparam int HOLD_ITEMS = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] px = '0, py = '0, pz = '0;
  logic [16:0] wt = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] mx, my, mz;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  point_attractor_deform_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .point_x_i   (px),
    .point_y_i   (py),
    .point_z_i   (pz),
    .weight_i    (wt),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .moved_x_o   (mx),
    .moved_y_o   (my),
    .moved_z_o   (mz),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // shadow copy of the configuration registers
  logic [2:0][31:0] att_r;
  logic [23:0]      fall_r;
  logic [16:0]      env_r;

  vertex_t pending_q[$];
  moved_t  moved_q[$];

  int  snd_idle = 0;
  int  rcv_idle = 0;
  bit  hold_req = 0;
  int  hold_cnt = 0;
  bit  in_took  = 0;
  int  errors   = 0;
  int  n_in = 0, n_out = 0, n_cfg = 0, n_zero = 0, n_sat = 0;
  int  wdog = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // attractor axis scaled by the clamped envelope, rounded on the magnitude
  function automatic logic signed [127:0] scaled_att(int i);
    logic signed [127:0] s, mag, e, r;
    s   = $signed(att_r[i]);
    e   = (env_r > ONE_Q16) ? ONE_Q16 : env_r;
    mag = (s < 0) ? -s : s;
    r   = (mag * e + 32768) >>> 16;
    return (s < 0) ? -r : r;
  endfunction

  function automatic logic signed [127:0] floor_sqrt(logic signed [127:0] v);
    logic signed [127:0] r, c;
    r = 0;
    for (int b = 35; b >= 0; b--) begin
      c = r | (128'sd1 <<< b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic moved_t predict_moved(vertex_t it);
    moved_t              res;
    logic signed [127:0] p[3], d[3], mag[3];
    logic signed [127:0] e, w, f, sum, len, root, t1, t2, t3, s;
    e   = (env_r > ONE_Q16) ? ONE_Q16 : env_r;
    w   = (it.w > ONE_Q16) ? ONE_Q16 : it.w;
    f   = (fall_r < FALL_MIN) ? FALL_MIN : fall_r;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      p[i]   = $signed(it.p[i]);
      d[i]   = scaled_att(i) - p[i];
      mag[i] = (d[i] < 0) ? -d[i] : d[i];
      sum    = sum + mag[i] * mag[i];
    end
    len = floor_sqrt(sum);
    if (len == 0) begin
      // zero offset leaves the vertex where it is
      for (int i = 0; i < 3; i++) res.m[i] = it.p[i];
      return res;
    end
    root = floor_sqrt(len <<< 16);
    for (int i = 0; i < 3; i++) begin
      t1 = (mag[i] * root + (len >>> 1)) / len;
      t2 = ((t1 <<< 16) + (f >>> 1)) / f;
      t3 = (t2 * w * e + 128'sh8000_0000) >>> 32;
      s  = p[i] + ((d[i] < 0) ? -t3 : t3);
      if (s > 128'sh7fff_ffff) s = 128'sh7fff_ffff;
      if (s < -128'sh8000_0000) s = -128'sh8000_0000;
      res.m[i] = s[31:0];
    end
    return res;
  endfunction

  // input driver, payload changes only after acceptance
  always @(negedge clk_i) begin
    if (!in_valid || in_took) begin
      if (pending_q.size() > 0 && $urandom_range(0, 99) >= snd_idle) begin
        vertex_t v;
        v = pending_q.pop_front();
        in_valid <= 1'b1;
        px <= v.p[0];
        py <= v.p[1];
        pz <= v.p[2];
        wt <= v.w;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver with random stalls and a long hold when asked
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_cnt = HOLD_LEN;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  // monitor: predict on input acceptance, compare on output acceptance
  always @(posedge clk_i) begin
    bit any;
    any = 0;
    in_took = in_valid && in_ready && rst_ni;
    if (in_took) begin
      vertex_t v;
      v.p[0] = px;
      v.p[1] = py;
      v.p[2] = pz;
      v.w    = wt;
      moved_q.push_back(predict_moved(v));
      n_in++;
      any = 1;
    end
    if (rst_ni && out_valid && out_ready) begin
      moved_t got, exp_m;
      any = 1;
      n_out++;
      got.m[0] = mx;
      got.m[1] = my;
      got.m[2] = mz;
      if (moved_q.size() == 0) begin
        $display("%0t: unexpected item x=%h y=%h z=%h", $time, mx, my, mz);
        errors++;
      end else begin
        exp_m = moved_q.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (got.m[i] !== exp_m.m[i]) begin
            $display("%0t: axis %0d expected %h actual %h", $time, i, exp_m.m[i], got.m[i]);
            errors++;
          end
          if (got.m[i] == 32'h7fff_ffff || got.m[i] == 32'h8000_0000) n_sat++;
        end
      end
    end
    if (rst_ni && cfg_valid && cfg_ready) any = 1;
    // watchdog on cycles with no handshake at all
    if (!rst_ni || any) wdog = 0;
    else wdog++;
    if (wdog >= WDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d items still expected", $time, moved_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // register write, only issued while the pipeline is empty
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(posedge clk_i);
      if (cfg_ready) break;
    end
    case (idx)
      CFG_ATT_X:   att_r[0] = val;
      CFG_ATT_Y:   att_r[1] = val;
      CFG_ATT_Z:   att_r[2] = val;
      CFG_FALLOFF: fall_r   = val[23:0];
      CFG_ENV:     env_r    = val[16:0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && moved_q.size() == 0 && !in_valid);
    repeat (NST + 10) @(posedge clk_i);
  endtask

  task automatic push_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [16:0] w);
    vertex_t v;
    v.p[0] = x;
    v.p[1] = y;
    v.p[2] = z;
    v.w    = w;
    if ($signed(x) == scaled_att(0) && $signed(y) == scaled_att(1) && $signed(z) == scaled_att(2))
      n_zero++;
    pending_q.push_back(v);
  endtask

  // random vertex, mostly near the attractor so the move is visible
  task automatic push_random();
    logic [2:0][31:0] p;
    logic [16:0]      w;
    int               mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      logic signed [127:0] a;
      a = scaled_att(i);
      case (mode)
        0, 1, 2: p[i] = $urandom;
        3, 4:    p[i] = a[31:0] + $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        5, 6:    p[i] = a[31:0] + $urandom_range(0, 512) - 256;
        7:       p[i] = a[31:0] + $urandom_range(0, 2) - 1;
        8:       p[i] = a[31:0];
        default: p[i] = ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
      endcase
    end
    case ($urandom_range(0, 9))
      0:       w = 17'd0;
      1:       w = ONE_Q16;
      2:       w = 17'($urandom_range(65537, 131071));
      default: w = 17'($urandom_range(0, 65536));
    endcase
    push_vertex(p[0], p[1], p[2], w);
  endtask

  initial begin
    att_r  = '0;
    fall_r = FALL_RST;
    env_r  = ONE_Q16;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed items against the reset settings
    snd_idle = 0;
    rcv_idle = 0;
    push_vertex(32'd0, 32'd0, 32'd0, ONE_Q16);              // zero offset
    push_vertex(32'h0001_0000, 32'd0, 32'd0, ONE_Q16);
    push_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, ONE_Q16);
    push_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, ONE_Q16);
    push_vertex(32'h7fff_ffff, 32'h8000_0000, 32'd1, 17'd0);
    push_vertex(32'hffff_ffff, 32'd1, 32'h0000_8000, 17'h1ffff); // weight above one
    push_vertex(32'd1, 32'd0, 32'd0, 17'd1);
    push_vertex(32'h0000_0100, 32'hffff_ff00, 32'd7, 17'd32768);
    drain();

    // saturation: attractor at the edges of the range, vertices just inside, on and opposite them
    write_reg(CFG_ATT_X, 32'h7fff_ffff);
    write_reg(CFG_ATT_Y, 32'h8000_0000);
    write_reg(CFG_ATT_Z, 32'h7fff_ffff);
    write_reg(CFG_FALLOFF, 32'd65536);
    push_vertex(32'h7fff_fff0, 32'h8000_0010, 32'h7fff_ffff, ONE_Q16);
    push_vertex(32'h7fff_ff00, 32'h8000_0100, 32'h7fff_fff8, ONE_Q16);
    push_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, ONE_Q16); // zero offset
    push_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, ONE_Q16);
    drain();

    // falloff below one, envelope above one, then ignored indexes
    write_reg(CFG_FALLOFF, 32'd0);
    write_reg(CFG_ENV, 32'h0001_ffff);
    write_reg(3'd5, 32'hdead_beef);
    write_reg(3'd6, 32'h1234_5678);
    write_reg(3'd7, 32'hffff_ffff);
    push_vertex(32'h7fff_fffe, 32'h8000_0001, 32'h7fff_fff0, ONE_Q16);
    push_vertex(32'd0, 32'd0, 32'd0, ONE_Q16);
    push_vertex(32'h1234_5678, 32'h8765_4321, 32'h0, 17'h10001);
    drain();

    for (int ph = 0; ph < PHASE_N; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_ATT_X, 32'd0);
          write_reg(CFG_ATT_Y, 32'd0);
          write_reg(CFG_ATT_Z, 32'd0);
          write_reg(CFG_FALLOFF, {8'd0, FALL_RST});
          write_reg(CFG_ENV, {15'd0, ONE_Q16});
        end
        1: begin
          write_reg(CFG_ATT_X, $urandom);
          write_reg(CFG_ATT_Y, $urandom);
          write_reg(CFG_ATT_Z, $urandom);
          write_reg(CFG_FALLOFF, 32'h00ff_ffff);
          write_reg(CFG_ENV, 32'd0);
        end
        2: begin
          write_reg(CFG_FALLOFF, $urandom_range(65536, 300000));
          write_reg(CFG_ENV, $urandom_range(1, 65535));
        end
        3: begin
          write_reg(CFG_ATT_X, 32'h8000_0000);
          write_reg(CFG_ATT_Y, 32'h7fff_ffff);
          write_reg(CFG_ATT_Z, $urandom);
          write_reg(CFG_FALLOFF, $urandom_range(0, 65535));
          write_reg(CFG_ENV, {15'd0, ONE_Q16});
        end
        4: begin
          write_reg(CFG_ATT_X, $urandom_range(0, 32'h000f_ffff));
          write_reg(CFG_ATT_Y, 32'hfff0_0000);
          write_reg(CFG_ATT_Z, 32'h0001_0000);
          write_reg(CFG_FALLOFF, $urandom_range(65536, 16777215));
          write_reg(CFG_ENV, $urandom_range(65537, 131071));
        end
        default: begin
          write_reg(CFG_ATT_X, $urandom);
          write_reg(CFG_ATT_Y, $urandom);
          write_reg(CFG_ATT_Z, $urandom);
          write_reg(CFG_FALLOFF, 32'd65536);
          write_reg(CFG_ENV, $urandom_range(0, 65536));
        end
      endcase
      // idle pattern: sender light and receiver heavy, then swapped, then none
      if (ph < 2) begin
        snd_idle = 6;
        rcv_idle = 70;
      end else if (ph < 4) begin
        snd_idle = 70;
        rcv_idle = 6;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      // long receiver hold while the sender keeps offering more items than the
      // pipeline can hold, so the input side stalls
      if (ph == 4) hold_req = 1;
      for (int k = 0; k < ((ph == 4) ? HOLD_ITEMS : ITEMS_PER); k++) push_random();
      drain();
    end

    $display("covered %0d vertices, %0d moved vertices, %0d register writes", n_in, n_out, n_cfg);
    $display("zero offset cases %0d, saturated axes %0d", n_zero, n_sat);
    if (errors == 0 && moved_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/pad_pkg.sv
hw/rtl/pad_sqrt.sv
hw/rtl/pad_div.sv
hw/rtl/point_attractor_deform_top.sv
hw/rtl/pad_checker.sv
sim/tb_point_attractor_deform_top.sv
